>>> rtl/core/pwmps_pkg.sv
// Shared constants, types and state codes for the PWM prescaler and period solver.
package pwmps_pkg;

    localparam logic [31:0] CLOCK_HZ_RESET = 32'd84000000;
    localparam logic [31:0] PERIOD_MAX     = 32'd65535;
    localparam int          PRESCALE_STEPS = 11;
    localparam int          EXP_W          = 4;
    localparam int          PERIOD_W       = 16;
    localparam int          DIV_STEPS      = 32;
    localparam int          DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int          SHIFT_W        = EXP_W + 1;
    localparam int          ADDR_W         = 3;
    localparam logic        REG_CLOCK_HZ   = 1'b0;

    localparam logic [EXP_W-1:0]     EXP_LAST = EXP_W'(PRESCALE_STEPS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SEARCH,
        ST_WRITE_OK,
        ST_WRITE_ERR
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic srch_step;
        logic out_load_ok;
        logic out_load_err;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic div_last;
        logic fit;
        logic srch_last;
    } status_t;

endpackage

>>> rtl/core/pwmps_if.sv
// Item channel interfaces for the request and result sides.
interface pwmps_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] frequency;
    logic        center_aligned;

    modport source (output valid, output frequency, output center_aligned, input ready);
    modport sink   (input valid, input frequency, input center_aligned, output ready);
endinterface

interface pwmps_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [pwmps_pkg::EXP_W-1:0]       prescaler_exponent;
    logic [pwmps_pkg::PERIOD_W-1:0]    period;

    modport source (output valid, output ok, output prescaler_exponent, output period,
                    input ready);
    modport sink   (input valid, input ok, input prescaler_exponent, input period,
                    output ready);
endinterface

>>> rtl/core/pwmps_datapath.sv
// Datapath: restoring divider for clock/frequency, prescaler shift search, result register.
module pwmps_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pwmps_pkg::cmd_t                cmd,
    output pwmps_pkg::status_t             status,
    input  logic [31:0]                    clock_hz,
    input  logic [31:0]                    frequency,
    input  logic                           center_aligned,
    output logic                           ok,
    output logic [pwmps_pkg::EXP_W-1:0]    prescaler_exponent,
    output logic [pwmps_pkg::PERIOD_W-1:0] period
);

    logic [31:0]                       freq_reg;
    logic                              center_reg;
    logic                              err_reg;
    logic [32:0]                       rem_reg;
    logic [31:0]                       quo_reg;
    logic [pwmps_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [pwmps_pkg::EXP_W-1:0]       exp_reg;
    logic                              ok_reg;
    logic [pwmps_pkg::EXP_W-1:0]       exp_out_reg;
    logic [pwmps_pkg::PERIOD_W-1:0]    period_out_reg;

    logic [33:0]                       trial;
    logic [32:0]                       rem_shift;
    logic [pwmps_pkg::SHIFT_W-1:0]     shamt;
    logic [31:0]                       period_w;

    assign rem_shift = {rem_reg[31:0], quo_reg[31]};
    assign trial     = {1'b0, rem_shift} - {2'b00, freq_reg};
    assign shamt     = {1'b0, exp_reg} + pwmps_pkg::SHIFT_W'(center_reg);
    assign period_w  = quo_reg >> shamt;

    assign status.err       = err_reg;
    assign status.div_last  = (cnt_reg == pwmps_pkg::DIV_LAST);
    assign status.fit       = (period_w <= pwmps_pkg::PERIOD_MAX);
    assign status.srch_last = (exp_reg == pwmps_pkg::EXP_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg   <= frequency;
            center_reg <= center_aligned;
            err_reg    <= (frequency == 32'd0) || (frequency > clock_hz);
            rem_reg    <= '0;
            quo_reg    <= clock_hz;
            cnt_reg    <= '0;
            exp_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!trial[33])
            begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        else if (cmd.srch_step)
        begin
            exp_reg <= exp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg         <= 1'b0;
            exp_out_reg    <= '0;
            period_out_reg <= '0;
        end
        else if (cmd.out_load_ok)
        begin
            ok_reg         <= 1'b1;
            exp_out_reg    <= exp_reg;
            period_out_reg <= period_w[pwmps_pkg::PERIOD_W-1:0];
        end
        else if (cmd.out_load_err)
        begin
            ok_reg         <= 1'b0;
            exp_out_reg    <= '0;
            period_out_reg <= '0;
        end
    end

    assign ok                 = ok_reg;
    assign prescaler_exponent = exp_out_reg;
    assign period             = period_out_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ok_reg |-> (exp_out_reg == '0) && (period_out_reg == '0))
        else $error("error result carries nonzero fields");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        ok_reg |-> exp_out_reg <= pwmps_pkg::EXP_LAST)
        else $error("exponent out of range");

    a_load_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load_ok |=> ok_reg && (exp_out_reg == $past(exp_reg)))
        else $error("ok result not captured");

endmodule

>>> rtl/core/pwmps_ctrl.sv
// Controller: sequences load, divide, prescaler search and result hand-off.
module pwmps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output pwmps_pkg::cmd_t       cmd,
    input  pwmps_pkg::status_t    status
);

    pwmps_pkg::state_t state_reg;
    pwmps_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwmps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            pwmps_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pwmps_pkg::ST_DIVIDE;
                end
            end
            pwmps_pkg::ST_DIVIDE:
            begin
                if (status.err)
                begin
                    state_next = pwmps_pkg::ST_WRITE_ERR;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                    begin
                        state_next = pwmps_pkg::ST_SEARCH;
                    end
                end
            end
            pwmps_pkg::ST_SEARCH:
            begin
                if (status.fit)
                begin
                    state_next = pwmps_pkg::ST_WRITE_OK;
                end
                else if (status.srch_last)
                begin
                    state_next = pwmps_pkg::ST_WRITE_ERR;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            pwmps_pkg::ST_WRITE_OK:
            begin
                if (out_free)
                begin
                    cmd.out_load_ok = 1'b1;
                    state_next      = pwmps_pkg::ST_IDLE;
                end
            end
            pwmps_pkg::ST_WRITE_ERR:
            begin
                if (out_free)
                begin
                    cmd.out_load_err = 1'b1;
                    state_next       = pwmps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwmps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.out_load_ok || cmd.out_load_err)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;

    a_rise_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pwmps_pkg::ST_WRITE_OK)
                              || ($past(state_reg) == pwmps_pkg::ST_WRITE_ERR))
        else $error("result valid without a write state");

    a_divide_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pwmps_pkg::ST_DIVIDE) |=> (state_reg == pwmps_pkg::ST_DIVIDE)
                                             || (state_reg == pwmps_pkg::ST_SEARCH)
                                             || (state_reg == pwmps_pkg::ST_WRITE_ERR))
        else $error("illegal exit from divide");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load_ok || cmd.out_load_err) |-> (!out_valid_reg || rsp_ready))
        else $error("pending result overwritten");

endmodule

>>> rtl/core/pwm_period_prescaler_solver_core.sv
// Top level of the PWM prescaler and period solver: config register, controller, datapath.
// Each item takes clock_hz / frequency through a 32-step restoring divider (one quotient
// bit per cycle), then walks the prescaler exponents 0..10 one per cycle; an item with
// zero frequency or a frequency above clock_hz skips the divider and returns an error
// result. One item is in work at a time; the next item is accepted once the result sits
// in the output register. clock_hz (reset 84000000) is at byte address 0; it must be
// written only while no item is in work, which the block itself does not enforce.
module pwm_period_prescaler_solver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pwmps_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    pwmps_req_if.sink                      req,
    pwmps_rsp_if.source                    rsp
);

    logic [31:0]          clock_hz_reg;
    pwmps_pkg::cmd_t      cmd;
    pwmps_pkg::status_t   status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= pwmps_pkg::CLOCK_HZ_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == pwmps_pkg::REG_CLOCK_HZ))
        begin
            clock_hz_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == pwmps_pkg::REG_CLOCK_HZ) ? clock_hz_reg : 32'd0;

    pwmps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    pwmps_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .clock_hz           (clock_hz_reg),
        .frequency          (req.frequency),
        .center_aligned     (req.center_aligned),
        .ok                 (rsp.ok),
        .prescaler_exponent (rsp.prescaler_exponent),
        .period             (rsp.period)
    );

endmodule
